### rtl/hwse_pkg.sv
`timescale 1ns / 1ps
package hwse_pkg;

  // Field widths.
  localparam int WHEELS    = 3;
  localparam int WHEEL_W   = 2;
  localparam int COUNT_W   = 32;
  localparam int SCALE_W   = 28;
  localparam int WEIGHT_W  = 17;
  localparam int TIMEOUT_W = 24;
  localparam int PERIOD_W  = 20;
  localparam int DIR_W     = 2;
  localparam int SPEED_W   = 32;
  localparam int ANGLE_W   = 48;

  // Serial arithmetic widths.
  localparam int PROD_W  = 80;
  localparam int MPLR_W  = 32;
  localparam int DEN_W   = 28;
  localparam int QUO_W   = 33;
  localparam int ACC_W   = 50;
  localparam int EMA_STEPS = 17;

  // Constants.
  localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = 20'd20000;
  localparam logic [PERIOD_W-1:0] US_PER_S       = 20'd1000000;
  localparam logic [PERIOD_W-1:0] HALF_US_PER_S  = 20'd500000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = 17'd65536;

  // Register indexes.
  localparam logic [1:0] REG_REAR_SCALE  = 2'd0;
  localparam logic [1:0] REG_FRONT_SCALE = 2'd1;
  localparam logic [1:0] REG_WEIGHT      = 2'd2;
  localparam logic [1:0] REG_TIMEOUT     = 2'd3;

  // Direction code for motor off.
  localparam logic [DIR_W-1:0] DIR_OFF = 2'b00;

  typedef struct packed {
    logic [SCALE_W-1:0]   rear_scale;
    logic [SCALE_W-1:0]   front_scale;
    logic [WEIGHT_W-1:0]  filter_weight;
    logic [TIMEOUT_W-1:0] stop_timeout_us;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] mcand;
    logic [MPLR_W-1:0] mplr;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DEN_W-1:0]  den;
  } div_req_t;

endpackage

### rtl/hwse_mul.sv
`timescale 1ns / 1ps
module hwse_mul
  import hwse_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  mul_req_t          req,
  output logic              done,
  output logic [PROD_W-1:0] product
);

  logic              busy;
  logic [4:0]        cnt;
  logic [PROD_W-1:0] mc;
  logic [MPLR_W-1:0] mp;

  // Shift-add multiplier, one multiplier bit per cycle, least significant first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        product <= '0;
        mc      <= req.mcand;
        mp      <= req.mplr;
        cnt     <= '0;
        busy    <= 1'b1;
      end else if (busy) begin
        if (mp[0]) begin
          product <= product + mc;
        end
        mc  <= mc << 1;
        mp  <= mp >> 1;
        cnt <= cnt + 5'd1;
        if (cnt == 5'(MPLR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/hwse_div.sv
`timescale 1ns / 1ps
module hwse_div
  import hwse_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [QUO_W-1:0] quotient,
  output logic             overflow
);

  logic              busy;
  logic [6:0]        cnt;
  logic [PROD_W-1:0] dd;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W:0]    trial;
  logic              fits;

  // One quotient bit per cycle: shift in the next dividend bit and try the divisor.
  assign trial = {rem, dd[PROD_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dd       <= req.dividend;
        den      <= req.den;
        rem      <= '0;
        quotient <= '0;
        overflow <= 1'b0;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        quotient <= {quotient[QUO_W-2:0], fits};
        overflow <= overflow | quotient[QUO_W-1];
        dd       <= dd << 1;
        cnt      <= cnt + 7'd1;
        if (cnt == 7'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/hwse_core.sv
`timescale 1ns / 1ps
module hwse_core
  import hwse_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst,
  input  cfg_t                              cfg,
  input  logic                              start,
  input  logic [WHEELS-1:0][COUNT_W-1:0]    counts,
  input  logic [DIR_W-1:0]                  direction,
  input  logic [PERIOD_W-1:0]               period_in,
  input  logic                              out_free,
  output logic                              idle,
  output logic                              done,
  output logic [WHEELS-1:0][SPEED_W-1:0]    speeds,
  output logic [WHEELS-1:0][ANGLE_W-1:0]    angles
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DELTA = 4'd1;
  localparam logic [3:0] ST_MUL1  = 4'd2;
  localparam logic [3:0] ST_MUL2  = 4'd3;
  localparam logic [3:0] ST_DIV1  = 4'd4;
  localparam logic [3:0] ST_EMA   = 4'd5;
  localparam logic [3:0] ST_SPEED = 4'd6;
  localparam logic [3:0] ST_MUL3  = 4'd7;
  localparam logic [3:0] ST_DIV2  = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0]                         state;
  logic [WHEEL_W-1:0]                 wheel;
  logic [WHEELS-1:0][COUNT_W-1:0]     cnt_in;
  logic [PERIOD_W-1:0]                period;
  logic                               dir_off;
  logic                               held_neg;
  logic [COUNT_W-1:0]                 last_cnt [WHEELS];
  logic [SPEED_W-1:0]                 avg      [WHEELS];
  logic [31:0]                        idle_tmr [WHEELS];
  logic                               neg;
  logic                               spd_neg;

  mul_req_t          mul_req;
  div_req_t          div_req;
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;
  logic              div_done;
  logic [QUO_W-1:0]  div_q;
  logic              div_ovf;

  // Filter accumulator and its serial operands.
  logic [ACC_W-1:0]    ema_acc;
  logic [ACC_W-1:0]    ema_r;
  logic [ACC_W-1:0]    ema_a;
  logic [WEIGHT_W-1:0] ema_wv;
  logic [WEIGHT_W-1:0] ema_wc;
  logic [4:0]          ema_cnt;

  // Combinational helpers.
  logic [COUNT_W-1:0]  delta;
  logic [COUNT_W-1:0]  mag;
  logic [SCALE_W-1:0]  scale;
  logic [32:0]         idle_sum;
  logic [WEIGHT_W-1:0] wclamp;
  logic [QUO_W-1:0]    lim;
  logic [SPEED_W-1:0]  rmag;
  logic [SPEED_W-1:0]  raw;
  logic [ACC_W-1:0]    ema_round;
  logic [SPEED_W-1:0]  avg_new;
  logic [SPEED_W-1:0]  speed;
  logic [SPEED_W-1:0]  smag;
  logic [ANGLE_W-1:0]  inc;

  hwse_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mul_req),
    .done    (mul_done),
    .product (mul_prod)
  );

  hwse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q),
    .overflow (div_ovf)
  );

  // Wrapped count step and its magnitude.
  assign delta    = cnt_in[wheel] - last_cnt[wheel];
  assign mag      = delta[COUNT_W-1] ? (~delta + 1'b1) : delta;
  assign scale    = (wheel == '0) ? cfg.rear_scale : cfg.front_scale;
  assign idle_sum = {1'b0, idle_tmr[wheel]} + 33'(period);

  // Raw speed with saturation toward the sign of the step.
  assign wclamp = (cfg.filter_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.filter_weight;
  assign lim    = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
  assign rmag   = (div_ovf || div_q > lim) ? lim[SPEED_W-1:0] : div_q[SPEED_W-1:0];
  assign raw    = neg ? (~rmag + 1'b1) : rmag;

  // Rounded average, cleared after the idle timeout with the motor off.
  assign ema_round = ema_acc + ACC_W'(32768);
  always_comb begin
    avg_new = ema_round[SPEED_W+15:16];
    if (dir_off && idle_tmr[wheel] >= 32'(cfg.stop_timeout_us)) begin
      avg_new = '0;
    end
  end

  // Signed speed from the held direction.
  always_comb begin
    speed = avg_new;
    if (held_neg) begin
      speed = (avg_new == 32'h8000_0000) ? 32'h7FFF_FFFF : (~avg_new + 1'b1);
    end
    smag = speed[SPEED_W-1] ? (~speed + 1'b1) : speed;
  end

  assign inc  = ANGLE_W'(div_q);
  assign idle = (state == ST_IDLE);
  assign done = (state == ST_DONE) && out_free;

  // Sequencer: each wheel runs through the shared multiplier and divider in turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      wheel         <= '0;
      held_neg      <= 1'b0;
      mul_req.start <= 1'b0;
      div_req.start <= 1'b0;
      for (int i = 0; i < WHEELS; i++) begin
        last_cnt[i] <= '0;
        avg[i]      <= '0;
        idle_tmr[i] <= '0;
        angles[i]   <= '0;
      end
    end else begin
      mul_req.start <= 1'b0;
      div_req.start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cnt_in  <= counts;
            period  <= (period_in == '0) ? DEFAULT_PERIOD : period_in;
            dir_off <= (direction == DIR_OFF);
            if (direction != DIR_OFF) begin
              held_neg <= direction[DIR_W-1];
            end
            wheel <= '0;
            state <= ST_DELTA;
          end
        end
        ST_DELTA: begin
          neg             <= delta[COUNT_W-1];
          last_cnt[wheel] <= cnt_in[wheel];
          if (delta != '0) begin
            idle_tmr[wheel] <= '0;
          end else begin
            idle_tmr[wheel] <= idle_sum[32] ? 32'hFFFF_FFFF : idle_sum[31:0];
          end
          mul_req <= '{start: 1'b1, mcand: PROD_W'(scale), mplr: mag};
          state   <= ST_MUL1;
        end
        ST_MUL1: begin
          if (mul_done) begin
            mul_req <= '{start: 1'b1, mcand: mul_prod, mplr: MPLR_W'(US_PER_S)};
            state   <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          if (mul_done) begin
            div_req <= '{start: 1'b1, dividend: mul_prod, den: {period, 8'd0}};
            state   <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            ema_acc <= '0;
            ema_r   <= ACC_W'($signed(raw));
            ema_a   <= ACC_W'($signed(avg[wheel]));
            ema_wv  <= wclamp;
            ema_wc  <= WEIGHT_ONE - wclamp;
            ema_cnt <= '0;
            state   <= ST_EMA;
          end
        end
        ST_EMA: begin
          ema_acc <= ema_acc + (ema_wv[0] ? ema_r : '0) + (ema_wc[0] ? ema_a : '0);
          ema_r   <= ema_r << 1;
          ema_a   <= ema_a << 1;
          ema_wv  <= ema_wv >> 1;
          ema_wc  <= ema_wc >> 1;
          ema_cnt <= ema_cnt + 5'd1;
          if (ema_cnt == 5'(EMA_STEPS - 1)) begin
            state <= ST_SPEED;
          end
        end
        ST_SPEED: begin
          avg[wheel]    <= avg_new;
          speeds[wheel] <= speed;
          spd_neg       <= speed[SPEED_W-1];
          mul_req       <= '{start: 1'b1, mcand: PROD_W'(smag), mplr: MPLR_W'(period)};
          state         <= ST_MUL3;
        end
        ST_MUL3: begin
          if (mul_done) begin
            div_req <= '{start: 1'b1, dividend: mul_prod + PROD_W'(HALF_US_PER_S),
                         den: DEN_W'(US_PER_S)};
            state   <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            angles[wheel] <= spd_neg ? (angles[wheel] - inc) : (angles[wheel] + inc);
            if (wheel == WHEEL_W'(WHEELS - 1)) begin
              state <= ST_DONE;
            end else begin
              wheel <= wheel + 1'b1;
              state <= ST_DELTA;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/hall_wheel_speed_estimator.sv
`timescale 1ns / 1ps
// Hall wheel speed estimator for one rear and two front wheels.
// Input stream: one word per control tick with the three cumulative pulse
// counts, the motor direction and the tick period. Output stream: one word per
// tick with the signed speed (Q16.16 rad/s) and integrated angle (Q32.16 rad)
// of each wheel. The configuration channel is always ready and writes the
// scales, filter weight and stop timeout; write it only while the block is idle.
// Each wheel runs through a shared bit-serial multiplier and a bit-serial divider:
// two products and a quotient for the raw speed, a bit-serial filter pass, then a
// product and a quotient for the angle. A new word is taken once the previous
// tick's results sit in the output register.
// Reset clears counts, filters, timers and angles, sets the held direction to
// forward and loads the default register values. When the receiver stalls, the
// output word holds; the block finishes the next tick and then waits for the
// output register to free up before taking another word.
module hall_wheel_speed_estimator
  import hwse_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // rear_count, left_count, right_count, motor_direction, period_us, zero fill
  input  logic [119:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // rear_speed, rear_angle, left_speed, left_angle, right_speed, right_angle
  output logic [239:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [27:0]  cfg_data
);

  cfg_t                           cfg;
  logic                           core_idle;
  logic                           core_done;
  logic                           out_free;
  logic [WHEELS-1:0][COUNT_W-1:0] counts;
  logic [WHEELS-1:0][SPEED_W-1:0] speeds;
  logic [WHEELS-1:0][ANGLE_W-1:0] angles;

  assign cfg_ready = 1'b1;
  assign s_tready  = core_idle;
  assign out_free  = !m_tvalid || m_tready;

  assign counts[0] = s_tdata[31:0];
  assign counts[1] = s_tdata[63:32];
  assign counts[2] = s_tdata[95:64];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rear_scale      <= 28'd262144;
      cfg.front_scale     <= '0;
      cfg.filter_weight   <= 17'd32768;
      cfg.stop_timeout_us <= 24'd150000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_REAR_SCALE:  cfg.rear_scale      <= cfg_data;
        REG_FRONT_SCALE: cfg.front_scale     <= cfg_data;
        REG_WEIGHT:      cfg.filter_weight   <= cfg_data[WEIGHT_W-1:0];
        REG_TIMEOUT:     cfg.stop_timeout_us <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  hwse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (s_tvalid && core_idle),
    .counts    (counts),
    .direction (s_tdata[97:96]),
    .period_in (s_tdata[117:98]),
    .out_free  (out_free),
    .idle      (core_idle),
    .done      (core_done),
    .speeds    (speeds),
    .angles    (angles)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (core_done) begin
      m_tvalid <= 1'b1;
      m_tdata  <= {angles[2], speeds[2], angles[1], speeds[1], angles[0], speeds[0]};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

### bench/tb_hall_wheel_speed_estimator.sv
`timescale 1ns / 1ps
module tb_hall_wheel_speed_estimator;
  import hwse_pkg::*;

  // Direction encodings beside the package's motor off code.
  localparam logic [DIR_W-1:0] DIR_FWD      = 2'b01;
  localparam logic [DIR_W-1:0] DIR_REV      = 2'b11;
  localparam logic [DIR_W-1:0] DIR_ODD_REV  = 2'b10;
  localparam int               STALL_LIMIT  = 20000;
  localparam int               RANDOM_ITEMS = 255;
  localparam int               PHASES       = 6;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [119:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [239:0] m_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [27:0]  cfg_data;

  hall_wheel_speed_estimator DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock with a 4 ns period.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow registers and per-wheel state of the estimator.
  logic [SCALE_W-1:0]   sh_rear_scale;
  logic [SCALE_W-1:0]   sh_front_scale;
  logic [WEIGHT_W-1:0]  sh_weight;
  logic [TIMEOUT_W-1:0] sh_timeout;
  logic [31:0]          prev_count [WHEELS];
  longint               ema_speed  [WHEELS];
  logic [31:0]          idle_us    [WHEELS];
  int                   held_dir;
  logic [47:0]          angle_acc  [WHEELS];

  logic [239:0] pending_reports [$];
  int           fail_count;
  int           words_in;
  int           words_out;
  int           idle_pct;
  int           stall_pct;
  int           quiet_cycles;

  // One row of directed stimulus; known rows carry a typed expected word.
  typedef struct {
    logic [31:0]       counts [WHEELS];
    logic [DIR_W-1:0]  dir;
    logic [19:0]       period;
    bit                known;
    logic [239:0]      report;
  } tick_row_t;

  tick_row_t directed_rows [$];

  function automatic logic [119:0] pack_tick(logic [31:0] r, logic [31:0] l,
                                             logic [31:0] rt, logic [1:0] d,
                                             logic [19:0] p);
    return {2'b00, p, d, rt, l, r};
  endfunction

  function automatic void add_row(logic [31:0] r, logic [31:0] l, logic [31:0] rt,
                                  logic [1:0] d, logic [19:0] p, bit known);
    tick_row_t row;
    row.counts[0] = r;
    row.counts[1] = l;
    row.counts[2] = rt;
    row.dir       = d;
    row.period    = p;
    row.known     = known;
    row.report    = '0;
    directed_rows.push_back(row);
  endfunction

  // Advances the wheel state by one tick and returns the expected output word.
  function automatic logic [239:0] advance_wheels(logic [119:0] w);
    logic [1:0]   dbits;
    longint       p;
    longint       wt;
    int           dir;
    logic [31:0]  cnt;
    logic [31:0]  d;
    logic [31:0]  mag;
    bit           neg;
    logic [127:0] prod;
    logic [127:0] quo;
    logic [127:0] lim;
    longint       raw;
    longint       acc;
    longint       spd;
    longint       smag;
    longint       inc;
    longint       sum;
    logic [239:0] res;
    dbits = w[97:96];
    p     = longint'(w[117:98]);
    if (p == 0) p = longint'(DEFAULT_PERIOD);
    wt  = (sh_weight > WEIGHT_ONE) ? 65536 : longint'(sh_weight);
    dir = (dbits == DIR_OFF) ? 0 : ((dbits == DIR_FWD) ? 1 : -1);
    if (dir != 0) held_dir = dir;
    res = '0;
    for (int i = 0; i < WHEELS; i++) begin
      cnt = w[32*i +: 32];
      d   = cnt - prev_count[i];
      prev_count[i] = cnt;
      neg = d[31];
      mag = neg ? -d : d;
      // Raw speed: pulses times radians per pulse over the period.
      prod = 128'(mag) * 128'((i == 0) ? sh_rear_scale : sh_front_scale) * 128'(1000000);
      quo  = prod / (128'(p) * 128'(256));
      lim  = neg ? 128'(64'h8000_0000) : 128'(64'h7FFF_FFFF);
      if (quo > lim) quo = lim;
      raw = neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
      // Moving average rounded to nearest with a floor shift.
      acc = wt * raw + (65536 - wt) * ema_speed[i] + 32768;
      ema_speed[i] = acc >>> 16;
      // Idle timer saturates at the full 32-bit range.
      if (d != 0) idle_us[i] = '0;
      else begin
        sum = longint'(idle_us[i]) + p;
        idle_us[i] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
      end
      if (dir == 0 && idle_us[i] >= sh_timeout) ema_speed[i] = 0;
      spd = (held_dir < 0) ? -ema_speed[i] : ema_speed[i];
      if (spd > 2147483647) spd = 2147483647;
      // Angle integrates the signed speed, rounding half away from zero.
      smag = (spd < 0) ? -spd : spd;
      inc  = (smag * p + 500000) / 1000000;
      if (spd < 0) angle_acc[i] = angle_acc[i] - inc[47:0];
      else angle_acc[i] = angle_acc[i] + inc[47:0];
      res[80*i +: 32]      = spd[31:0];
      res[80*i + 32 +: 48] = angle_acc[i];
    end
    return res;
  endfunction

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Output checking and the no-progress watchdog, sampled mid-cycle.
  always @(negedge clk) begin
    logic [239:0] want;
    if (!rst && m_tvalid && m_tready) begin
      words_out++;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected output word %h", $time, m_tdata);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        for (int i = 0; i < WHEELS; i++) begin
          if (m_tdata[80*i +: 32] !== want[80*i +: 32]) begin
            $display("%0t: wheel %0d speed expected %h actual %h", $time, i,
                     want[80*i +: 32], m_tdata[80*i +: 32]);
            fail_count++;
          end
          if (m_tdata[80*i + 32 +: 48] !== want[80*i + 32 +: 48]) begin
            $display("%0t: wheel %0d angle expected %h actual %h", $time, i,
                     want[80*i + 32 +: 48], m_tdata[80*i + 32 +: 48]);
            fail_count++;
          end
        end
      end
    end
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Writes one register and mirrors it into the shadow copy.
  task automatic write_reg(logic [1:0] idx, logic [27:0] val);
    bit rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    case (idx)
      REG_REAR_SCALE:  sh_rear_scale  = val[SCALE_W-1:0];
      REG_FRONT_SCALE: sh_front_scale = val[SCALE_W-1:0];
      REG_WEIGHT:      sh_weight      = val[WEIGHT_W-1:0];
      REG_TIMEOUT:     sh_timeout     = val[TIMEOUT_W-1:0];
      default: ;
    endcase
  endtask

  // Sends one input word; a typed expectation replaces the predicted one if given.
  task automatic send_tick(logic [119:0] word, bit known, logic [239:0] typed);
    bit           rdy;
    logic [239:0] want;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
    want = advance_wheels(word);
    pending_reports.push_back(known ? typed : want);
    words_in++;
  endtask

  // Waits until every expected word has come out, then lets the block settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  // Random count step: mostly small moves, some stops, jumps and wild values.
  function automatic logic [31:0] next_count(logic [31:0] c);
    int r;
    r = $urandom_range(99);
    if (r < 20) return c;
    if (r < 75) return $urandom_range(1) ? c + $urandom_range(200) : c - $urandom_range(200);
    if (r < 90) return $urandom_range(1) ? c + $urandom_range(100000) : c - $urandom_range(100000);
    return $urandom;
  endfunction

  initial begin
    logic [27:0]  phase_cfg [PHASES][4];
    logic [31:0]  cur [WHEELS];
    logic [19:0]  per;
    logic [1:0]   dir;
    int           r;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_REAR_SCALE;
    cfg_data = '0;
    fail_count = 0;
    words_in = 0;
    words_out = 0;
    quiet_cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    sh_rear_scale = 28'd262144;
    sh_front_scale = '0;
    sh_weight = 17'd32768;
    sh_timeout = 24'd150000;
    held_dir = 1;
    for (int i = 0; i < WHEELS; i++) begin
      prev_count[i] = '0;
      ema_speed[i] = 0;
      idle_us[i] = '0;
      angle_acc[i] = '0;
      cur[i] = '0;
    end

    // Register settings per phase, extremes among them.
    phase_cfg[0] = '{28'd262144, 28'd3294199, 28'd32768, 28'd150000};
    phase_cfg[1] = '{28'hFFFFFFF, 28'hFFFFFFF, 28'd65536, 28'd0};
    phase_cfg[2] = '{28'd1, 28'd0, 28'h1FFFF, 28'd10000000};
    phase_cfg[3] = '{28'd0, 28'hFFFFFFF, 28'd0, 28'd1};
    phase_cfg[4] = '{28'd5000000, 28'd1000000, 28'd20000, 28'd40000};
    phase_cfg[5] = '{28'hA00000, 28'h1234567, 28'd60000, 28'd200000};

    // Directed ticks: reset state, wrap, backward jumps, direction codes, periods.
    add_row(32'd0, 32'd0, 32'd0, DIR_FWD, 20'd0, 1'b1);
    add_row(32'd0, 32'd0, 32'd0, DIR_OFF, 20'd0, 1'b1);
    add_row(32'd10, 32'd5, 32'd3, DIR_FWD, 20'd20000, 1'b0);
    add_row(32'd20, 32'd2, 32'd1, DIR_FWD, 20'd20000, 1'b0);
    add_row(32'h8000_0013, 32'h8000_0001, 32'hFFFF_FFFF, DIR_FWD, 20'd1, 1'b0);
    add_row(32'h0000_0013, 32'h0000_0001, 32'h7FFF_FFFE, DIR_FWD, 20'd1, 1'b0);
    add_row(32'd30, 32'd40, 32'h7FFF_FFF0, DIR_REV, 20'd1000000, 1'b0);
    add_row(32'd40, 32'd50, 32'h7FFF_FFE0, DIR_ODD_REV, 20'hFFFFF, 1'b0);
    add_row(32'd40, 32'd50, 32'h7FFF_FFE0, DIR_OFF, 20'd50000, 1'b0);
    add_row(32'd40, 32'd50, 32'h7FFF_FFE0, DIR_OFF, 20'd50000, 1'b0);
    add_row(32'd40, 32'd50, 32'h7FFF_FFE0, DIR_OFF, 20'd60000, 1'b0);
    add_row(32'd40, 32'd50, 32'h7FFF_FFE0, DIR_OFF, 20'd0, 1'b0);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, DIR_FWD, 20'd1, 1'b0);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, DIR_OFF, 20'hFFFFF, 1'b0);
    add_row(32'h1000_0000, 32'h2000_0000, 32'h4000_0000, DIR_REV, 20'd500, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k])
      send_tick(pack_tick(directed_rows[k].counts[0], directed_rows[k].counts[1],
                          directed_rows[k].counts[2], directed_rows[k].dir,
                          directed_rows[k].period),
                directed_rows[k].known, directed_rows[k].report);
    for (int i = 0; i < WHEELS; i++) cur[i] = prev_count[i];
    drain();

    // Random phases, each with fresh registers and an idling pattern chosen by phase.
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 6 : 50) : 0;
      stall_pct = (ph % 4 == 2) ? 50 : ((ph % 4 == 3) ? 6 : 0);
      write_reg(REG_REAR_SCALE,  phase_cfg[ph][0]);
      write_reg(REG_FRONT_SCALE, phase_cfg[ph][1]);
      write_reg(REG_WEIGHT,      phase_cfg[ph][2]);
      write_reg(REG_TIMEOUT,     phase_cfg[ph][3]);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        for (int i = 0; i < WHEELS; i++) cur[i] = next_count(cur[i]);
        dir = 2'($urandom_range(3));
        r = $urandom_range(99);
        if (r < 40) per = DEFAULT_PERIOD;
        else if (r < 55) per = '0;
        else if (r < 80) per = 20'($urandom_range(50000, 1000));
        else if (r < 95) per = 20'($urandom_range(20'hFFFFF));
        else per = $urandom_range(1) ? 20'd1 : 20'hFFFFF;
        send_tick(pack_tick(cur[0], cur[1], cur[2], dir, per), 1'b0, '0);
      end
      drain();
    end

    $display("Sent %0d ticks and checked %0d output words over %0d register settings,",
             words_in, words_out, PHASES + 1);
    $display("with sender gaps and receiver stalls varied per phase.");
    if (fail_count == 0 && pending_reports.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d words never arrived", fail_count, pending_reports.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
